// ----- rtl/sdq_pkg.sv -----
package sdq_pkg;

  localparam int OP_W   = 3;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 9;
  localparam int CFG_W  = 9;
  localparam int RESET_CAP = 16;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam logic [OP_W-1:0] OP_INS_HEAD  = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_TAIL  = 3'd1;
  localparam logic [OP_W-1:0] OP_REM_HEAD  = 3'd2;
  localparam logic [OP_W-1:0] OP_REM_TAIL  = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_HEAD = 3'd4;
  localparam logic [OP_W-1:0] OP_PEEK_TAIL = 3'd5;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// ----- rtl/shift_to_middle_deque.sv -----
// double-ended queue held as a run [head, tail) in a single-port-write store
// s_axis carries one operation per transaction: insert, remove or peek at
// either end, with the element to insert; m_axis returns exactly one result
// per operation: success, peeked element, empty flag and element count
// cfg carries the starting capacity; a write empties the queue and places
// head and tail at half the capacity (taken only while the block is idle)
// an operation is accepted in the idle state; peeks, removes and inserts that
// find room go straight to the finish state, which loads the result into the
// output register once no earlier result waits; only then is another taken
// an insert that runs out of room doubles the capacity one step per cycle
// until the chosen end has room (it fails if doubling would pass DEPTH),
// then re-centres the run by copying it through the store's read and write
// ports, one element per cycle, after which the MVEND state flushes the
// copy pipeline; no copy runs when nothing has to move
// reset empties the queue with capacity 16 (or DEPTH if smaller); the store
// is not cleared and needs no start-up pass
// a stalled receiver holds the result in the output register; one further
// operation may be accepted and worked, and waits to load until it drains
module shift_to_middle_deque #(
  parameter int DEPTH     = 256,
  parameter int ELEM_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // [2:0] operation, [34:3] elem_in
  input  logic [sdq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [0] success, [32:1] elem_out, [33] is_empty, [42:34] count
  output logic [sdq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [sdq_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int IW = $clog2(DEPTH + 1);
  localparam int ResetCap = (sdq_pkg::RESET_CAP > DEPTH) ? DEPTH : sdq_pkg::RESET_CAP;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_GROW   = 3'd1;
  localparam logic [2:0] ST_MOVE   = 3'd2;
  localparam logic [2:0] ST_MVEND  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [IW-1:0]               head_q, head_d, tail_q, tail_d, cap_q, cap_d;
  logic [IW-1:0]               gh_q, gh_d, gcap_q, gcap_d, n_q, n_d, mv_q, mv_d;
  logic [sdq_pkg::OP_W-1:0]    op_q, op_d;
  logic [ELEM_BITS-1:0]        elem_q, elem_d;
  logic                        fail_q, fail_d;
  logic                        wr_pend_q, wr_pend_d;
  logic [AW-1:0]               wr_addr_q, wr_addr_d;
  logic                        out_valid_q, out_valid_d;
  logic [sdq_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic                        in_fire, cfg_fire, fin_fire;
  logic [sdq_pkg::OP_W-1:0]    in_op;
  logic [63:0]                 in_ext, rd_ext;
  logic [31:0]                 cfg_cap32;
  sdq_pkg::mem_ctl_t           mem_ctl;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [ELEM_BITS-1:0]        mem_wdata, mem_rdata;

  // growth step
  logic [IW:0]                 dbl, grow_sum;
  logic                        grow_room, too_big;

  // re-centring copy
  logic                        mv_up;
  logic [IW-1:0]               mv_k, mv_src, mv_dst;

  // finishing step
  logic [IW-1:0]               base_t, new_h, new_t, new_n;
  logic                        fin_ok, fin_wr;
  logic [AW-1:0]               fin_waddr;
  logic [sdq_pkg::DATA_W-1:0]  fin_elem;

  assign in_op     = s_axis_tdata[2:0];
  assign in_ext    = 64'(s_axis_tdata[34:3]);
  assign rd_ext    = 64'(mem_rdata);
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign cfg_fire  = cfg_valid_i && cfg_ready_o;
  assign fin_fire  = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_cap32 = 32'd1;
    end else if (32'(cfg_data_i) > 32'(DEPTH)) begin
      cfg_cap32 = 32'(DEPTH);
    end else begin
      cfg_cap32 = 32'(cfg_data_i);
    end
  end

  assign dbl       = {gcap_q, 1'b0};
  assign too_big   = dbl > (IW+1)'(DEPTH);
  assign grow_sum  = {1'b0, gh_q} + {1'b0, n_q};
  assign grow_room = (op_q == sdq_pkg::OP_INS_HEAD) ? (gh_q != '0)
                                                    : (grow_sum < {1'b0, gcap_q});

  // copy top-down when the run moves up, bottom-up when it moves down
  assign mv_up  = gh_q > head_q;
  assign mv_k   = mv_up ? (n_q - IW'(1) - mv_q) : mv_q;
  assign mv_src = head_q + mv_k;
  assign mv_dst = gh_q + mv_k;

  always_comb begin
    base_t    = gh_q + n_q;
    new_h     = gh_q;
    new_t     = base_t;
    fin_ok    = 1'b0;
    fin_wr    = 1'b0;
    fin_waddr = base_t[AW-1:0];
    fin_elem  = '0;
    case (op_q)
      sdq_pkg::OP_INS_HEAD: begin
        if (!fail_q) begin
          new_h     = gh_q - IW'(1);
          fin_waddr = new_h[AW-1:0];
          fin_ok    = 1'b1;
          fin_wr    = 1'b1;
        end
      end
      sdq_pkg::OP_INS_TAIL: begin
        if (!fail_q) begin
          new_t  = base_t + IW'(1);
          fin_ok = 1'b1;
          fin_wr = 1'b1;
        end
      end
      sdq_pkg::OP_REM_HEAD: begin
        if (n_q != '0) begin
          new_h  = gh_q + IW'(1);
          fin_ok = 1'b1;
        end
      end
      sdq_pkg::OP_REM_TAIL: begin
        if (n_q != '0) begin
          new_t  = base_t - IW'(1);
          fin_ok = 1'b1;
        end
      end
      sdq_pkg::OP_PEEK_HEAD, sdq_pkg::OP_PEEK_TAIL: begin
        if (n_q != '0) begin
          fin_elem = rd_ext[31:0];
          fin_ok   = 1'b1;
        end
      end
      default: ;
    endcase
    new_n = new_t - new_h;
  end

  // store ports: copy writes, insert writes, peek reads and copy reads
  always_comb begin
    mem_ctl.we = wr_pend_q || (fin_fire && fin_wr);
    mem_ctl.re = (state_q == ST_MOVE) ||
                 (in_fire && ((in_op == sdq_pkg::OP_PEEK_HEAD) ||
                              (in_op == sdq_pkg::OP_PEEK_TAIL)));
    mem_waddr  = wr_pend_q ? wr_addr_q : fin_waddr;
    mem_wdata  = wr_pend_q ? mem_rdata : elem_q;
    if (state_q == ST_MOVE) begin
      mem_raddr = mv_src[AW-1:0];
    end else if (in_op == sdq_pkg::OP_PEEK_HEAD) begin
      mem_raddr = head_q[AW-1:0];
    end else begin
      mem_raddr = AW'(tail_q - IW'(1));
    end
  end

  sdq_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .W     (ELEM_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cap_d       = cap_q;
    gh_d        = gh_q;
    gcap_d      = gcap_q;
    n_d         = n_q;
    mv_d        = mv_q;
    op_d        = op_q;
    elem_d      = elem_q;
    fail_d      = fail_q;
    wr_pend_d   = (state_q == ST_MOVE);
    wr_addr_d   = mv_dst[AW-1:0];
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_fire) begin
          cap_d  = IW'(cfg_cap32);
          head_d = IW'(cfg_cap32 >> 1);
          tail_d = IW'(cfg_cap32 >> 1);
        end
        if (in_fire) begin
          op_d   = in_op;
          elem_d = in_ext[ELEM_BITS-1:0];
          gh_d   = head_q;
          gcap_d = cap_q;
          n_d    = tail_q - head_q;
          fail_d = 1'b0;
          if (((in_op == sdq_pkg::OP_INS_HEAD) && (head_q == '0)) ||
              ((in_op == sdq_pkg::OP_INS_TAIL) && (tail_q >= cap_q))) begin
            state_d = ST_GROW;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_GROW: begin
        if (grow_room) begin
          mv_d = '0;
          if ((gh_q != head_q) && (n_q != '0)) begin
            state_d = ST_MOVE;
          end else begin
            state_d = ST_FINISH;
          end
        end else if (too_big) begin
          fail_d  = 1'b1;
          gh_d    = head_q;
          gcap_d  = cap_q;
          state_d = ST_FINISH;
        end else begin
          gcap_d = dbl[IW-1:0];
          gh_d   = IW'((dbl - {1'b0, n_q}) >> 1);
        end
      end
      ST_MOVE: begin
        mv_d = mv_q + IW'(1);
        if (mv_q == n_q - IW'(1)) begin
          state_d = ST_MVEND;
        end
      end
      ST_MVEND: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (fin_fire) begin
          head_d      = new_h;
          tail_d      = new_t;
          cap_d       = gcap_q;
          out_valid_d = 1'b1;
          out_data_d  = sdq_pkg::OUT_TDATA_W'({sdq_pkg::CNT_W'(new_n),
                                               (new_n == '0), fin_elem, fin_ok});
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= IW'(ResetCap / 2);
      tail_q      <= IW'(ResetCap / 2);
      cap_q       <= IW'(ResetCap);
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cap_q       <= cap_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gh_q       <= gh_d;
    gcap_q     <= gcap_d;
    n_q        <= n_d;
    mv_q       <= mv_d;
    op_q       <= op_d;
    elem_q     <= elem_d;
    fail_q     <= fail_d;
    wr_addr_q  <= wr_addr_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // the run always lies inside the logical capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= tail_q) && (tail_q <= cap_q))
    else $error("run outside capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q != '0) && (32'(cap_q) <= 32'(DEPTH)))
    else $error("capacity out of range");

  // copy writes only trail copy reads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> ((state_q == ST_MOVE) || (state_q == ST_MVEND)))
    else $error("stray copy write");

  // a finished result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(out_data_q))
    else $error("pending result overwritten");

endmodule

// ----- rtl/sdq_store.sv -----
module sdq_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int W     = 32
) (
  input  logic              clk_i,
  input  sdq_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [W-1:0]      wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [W-1:0]      rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- dv/shift_to_middle_deque_tb.sv -----
`timescale 1ns / 100ps

module shift_to_middle_deque_tb;

  localparam int OP_W        = sdq_pkg::OP_W;
  localparam int DATA_W      = sdq_pkg::DATA_W;
  localparam int CNT_W       = sdq_pkg::CNT_W;
  localparam int CFG_W       = sdq_pkg::CFG_W;
  localparam int IN_TDATA_W  = sdq_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = sdq_pkg::OUT_TDATA_W;
  localparam int RESET_CAP   = sdq_pkg::RESET_CAP;

  localparam logic [OP_W-1:0] OP_INS_HEAD  = sdq_pkg::OP_INS_HEAD;
  localparam logic [OP_W-1:0] OP_INS_TAIL  = sdq_pkg::OP_INS_TAIL;
  localparam logic [OP_W-1:0] OP_REM_HEAD  = sdq_pkg::OP_REM_HEAD;
  localparam logic [OP_W-1:0] OP_REM_TAIL  = sdq_pkg::OP_REM_TAIL;
  localparam logic [OP_W-1:0] OP_PEEK_HEAD = sdq_pkg::OP_PEEK_HEAD;
  localparam logic [OP_W-1:0] OP_PEEK_TAIL = sdq_pkg::OP_PEEK_TAIL;

  localparam int QUEUE_DEPTH = 256;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;
  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] elem;
  } deque_op_t;

  typedef struct {
    logic              success;
    logic [DATA_W-1:0] elem_out;
    logic              is_empty;
    logic [CNT_W-1:0]  count;
  } deque_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;

  deque_op_t     pending_ops[$];
  deque_result_t expected_results[$];

  // predicted deque contents and bounds
  logic [DATA_W-1:0] model_store [QUEUE_DEPTH];
  int unsigned       q_head;
  int unsigned       q_tail;
  int unsigned       q_cap;

  int  send_gap_pct;
  int  recv_gap_pct;
  int  ops_accepted;
  int  errors;
  int  cycles;
  int  hold_left;
  int  hold_at;
  bit  hold_done;
  bit  in_taken;

  shift_to_middle_deque #(
    .DEPTH     (QUEUE_DEPTH),
    .ELEM_BITS (DATA_W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data_i    (cfg_data_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic void deque_restart(input logic [CFG_W-1:0] value);
    int unsigned c;
    c = value;
    if (c < 1) c = 1;
    if (c > QUEUE_DEPTH) c = QUEUE_DEPTH;
    q_cap  = c;
    q_head = c / 2;
    q_tail = q_head;
  endfunction

  // doubles the capacity until the chosen end has room, then re-centres the run
  function automatic bit deque_make_room(input bit at_head);
    logic [DATA_W-1:0] snap [QUEUE_DEPTH];
    int unsigned n, c, h;
    n = q_tail - q_head;
    c = q_cap;
    h = q_head;
    while (at_head ? (h == 0) : (h + n >= c)) begin
      if (2 * c > QUEUE_DEPTH) return 1'b0;
      c = 2 * c;
      h = (c - n) / 2;
    end
    for (int i = 0; i < n; i++) snap[i] = model_store[q_head + i];
    for (int i = 0; i < n; i++) model_store[h + i] = snap[i];
    q_head = h;
    q_tail = h + n;
    q_cap  = c;
    return 1'b1;
  endfunction

  function automatic deque_result_t deque_apply(input logic [OP_W-1:0] op,
                                                input logic [DATA_W-1:0] elem);
    deque_result_t r;
    bit nonempty;
    nonempty   = q_tail > q_head;
    r.success  = 1'b0;
    r.elem_out = '0;
    case (op)
      OP_INS_HEAD: begin
        if (deque_make_room(1'b1)) begin
          q_head--;
          model_store[q_head] = elem;
          r.success = 1'b1;
        end
      end
      OP_INS_TAIL: begin
        if (deque_make_room(1'b0)) begin
          model_store[q_tail] = elem;
          q_tail++;
          r.success = 1'b1;
        end
      end
      OP_REM_HEAD: begin
        if (nonempty) begin
          q_head++;
          r.success = 1'b1;
        end
      end
      OP_REM_TAIL: begin
        if (nonempty) begin
          q_tail--;
          r.success = 1'b1;
        end
      end
      OP_PEEK_HEAD: begin
        if (nonempty) begin
          r.elem_out = model_store[q_head];
          r.success  = 1'b1;
        end
      end
      OP_PEEK_TAIL: begin
        if (nonempty) begin
          r.elem_out = model_store[q_tail - 1];
          r.success  = 1'b1;
        end
      end
      default: ;
    endcase
    r.is_empty = (q_head == q_tail);
    r.count    = CNT_W'(q_tail - q_head);
    return r;
  endfunction

  // sender: a new operation only once the previous one has gone
  always @(negedge clk_i) begin
    deque_op_t item;
    if (!s_axis_tvalid || in_taken) begin
      if (rst_ni && pending_ops.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        item = pending_ops.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - OP_W - DATA_W){1'b0}}, item.elem, item.op};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_gap_pct);
  end

  // long receiver hold-off, started once the chosen operation count is reached
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && ops_accepted >= hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    deque_result_t want;
    deque_result_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(deque_apply(s_axis_tdata[OP_W-1:0],
                                               s_axis_tdata[OP_W+DATA_W-1:OP_W]));
        ops_accepted <= ops_accepted + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.success  = m_axis_tdata[0];
        got.elem_out = m_axis_tdata[DATA_W:1];
        got.is_empty = m_axis_tdata[DATA_W+1];
        got.count    = m_axis_tdata[DATA_W+CNT_W+1:DATA_W+2];
        if (expected_results.size() == 0) begin
          $error("result transaction with no operation outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.success !== want.success) begin
            $error("success: expected %0d, got %0d", want.success, got.success);
            errors++;
          end
          if (got.elem_out !== want.elem_out) begin
            $error("elem_out: expected 0x%08h, got 0x%08h", want.elem_out, got.elem_out);
            errors++;
          end
          if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
            errors++;
          end
          if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            errors++;
          end
        end
      end
    end
    in_taken <= s_axis_tvalid && s_axis_tready;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] elem);
    deque_op_t item;
    item.op   = op;
    item.elem = elem;
    pending_ops.push_back(item);
  endtask

  function automatic logic [DATA_W-1:0] random_elem();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return ALL_ONES;
    return $urandom();
  endfunction

  // inserts lean towards one end when bias is high, so that end runs out of room
  task automatic queue_segment(input int len, input int p_ins, input int p_rem,
                               input int p_peek, input int bias, input bit home_head);
    int r;
    bit at_head;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < p_ins) begin
        at_head = ($urandom_range(99) < bias) ? home_head : !home_head;
        queue_op(at_head ? OP_INS_HEAD : OP_INS_TAIL, random_elem());
      end else if (r < p_ins + p_rem) begin
        queue_op($urandom_range(1) ? OP_REM_HEAD : OP_REM_TAIL, random_elem());
      end else if (r < p_ins + p_rem + p_peek) begin
        queue_op($urandom_range(1) ? OP_PEEK_HEAD : OP_PEEK_TAIL, random_elem());
      end else begin
        queue_op($urandom_range(1) ? OP_RSVD_A : OP_RSVD_B, random_elem());
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    deque_restart(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] cap, input int grow_len,
                           input int mix_len, input int shrink_len);
    bit home_head;
    wait_drained();
    write_capacity(cap);
    @(posedge clk_i);
    home_head = $urandom_range(1);
    queue_segment(grow_len, 88, 3, 6, 95, home_head);
    queue_segment(mix_len, 35, 30, 30, 50, home_head);
    queue_segment(shrink_len, 7, 75, 15, 50, home_head);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_data_i    = '0;
    cfg_valid_i   = 1'b0;
    ops_accepted  = 0;
    errors        = 0;
    cycles        = 0;
    hold_left     = 0;
    hold_at       = 32'h7fffffff;
    hold_done     = 1'b0;
    in_taken      = 1'b0;
    send_gap_pct  = 7;
    recv_gap_pct  = 83;
    deque_restart(CFG_W'(RESET_CAP));
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // empty queue after reset, unused codes, element extremes
    queue_op(OP_REM_HEAD, '0);
    queue_op(OP_REM_TAIL, ALL_ONES);
    queue_op(OP_PEEK_HEAD, ALL_ONES);
    queue_op(OP_PEEK_TAIL, '0);
    queue_op(OP_RSVD_A, ALL_ONES);
    queue_op(OP_RSVD_B, ALL_ONES);
    queue_op(OP_INS_HEAD, '0);
    queue_op(OP_INS_TAIL, ALL_ONES);
    queue_op(OP_PEEK_HEAD, '0);
    queue_op(OP_PEEK_TAIL, '0);
    queue_op(OP_INS_HEAD, 32'ha5a5_a5a5);
    queue_op(OP_REM_HEAD, '0);
    queue_op(OP_REM_TAIL, '0);
    queue_op(OP_PEEK_TAIL, '0);
    queue_op(OP_REM_TAIL, '0);
    queue_op(OP_REM_HEAD, '0);
    wait_drained();

    // zero capacity clamps to one; a head insert then has to double twice
    write_capacity('0);
    @(posedge clk_i);
    queue_op(OP_INS_TAIL, 32'h1234_5678);
    queue_op(OP_INS_HEAD, 32'hdead_beef);
    queue_op(OP_PEEK_HEAD, '0);
    queue_op(OP_PEEK_TAIL, '0);
    queue_op(OP_INS_HEAD, 32'h8000_0001);
    queue_op(OP_PEEK_HEAD, '0);

    run_phase(9'd1, 90, 30, 40);
    run_phase(9'd256, 200, 20, 40);

    wait_drained();
    send_gap_pct = 83;
    recv_gap_pct = 7;
    run_phase(9'd511, 180, 20, 60);
    run_phase(9'd2, 60, 30, 30);

    wait_drained();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_at      = ops_accepted + 10;
    run_phase(CFG_W'($urandom_range(3, 255)), 60, 40, 40);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
